// ----- rtl/swsp_pkg.sv -----
// ----------------------------------------------------------------------------
// swsp_pkg
// Shared types and constants for the stopwatch with split table.
// ----------------------------------------------------------------------------
package swsp_pkg;

  localparam int TIME_W    = 32;
  localparam int LABEL_W   = 16;
  localparam int REQ_W     = 4;
  localparam int IDX_W     = 6;
  localparam int TOTAL_W   = 7;
  localparam int ENTRY_W   = TIME_W + LABEL_W;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 96;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 4'd0,
    REQ_START      = 4'd1,
    REQ_STOP       = 4'd2,
    REQ_STOP_AT    = 4'd3,
    REQ_RESET      = 4'd4,
    REQ_PAUSE      = 4'd5,
    REQ_RESUME     = 4'd6,
    REQ_SPLIT_NOW  = 4'd7,
    REQ_SPLIT_AT   = 4'd8,
    REQ_READ_SPLIT = 4'd9
  } req_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_IDX,
    OP_RD_POS,
    OP_POS_INC,
    OP_RD_KM1,
    OP_WR_K,
    OP_COMMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCAN_CHK,
    ST_SCAN_CMP,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;        // table holds MAX_SPLITS entries
    logic pos_at_end;  // scan position reached entry count
    logic entry_lt;    // entry just read is earlier than the split time
    logic k_gt_pos;    // shift pointer still above insert slot
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic               split_dropped;
    logic               split_valid;
    logic [LABEL_W-1:0] split_label;
    logic [TIME_W-1:0]  split_time;
    logic [TOTAL_W-1:0] split_total;
    logic               is_finished;
    logic               is_paused;
    logic               is_running;
    logic [TIME_W-1:0]  elapsed_ticks;
  } result_t;

endpackage

// ----- rtl/swsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// swsp_ctrl
// Sequencer: accepts a beat, walks the split table for sorted inserts and
// reads, and commits the request once the output register is free.
// ----------------------------------------------------------------------------
module swsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  swsp_pkg::dp_stat_t stat,
  output swsp_pkg::dp_cmd_t  cmd
);

  swsp_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = swsp_pkg::OP_NOP;
    s_tready   = 1'b0;
    unique case (state)
      swsp_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.op     = swsp_pkg::OP_LOAD;
          state_next = swsp_pkg::ST_EXEC;
        end
      end
      swsp_pkg::ST_EXEC: begin
        priority if (stat.req == swsp_pkg::REQ_READ_SPLIT) begin
          cmd.op     = swsp_pkg::OP_RD_IDX;
          state_next = swsp_pkg::ST_RD_WAIT;
        end else if (stat.req == swsp_pkg::REQ_SPLIT_AT && !stat.full) begin
          state_next = swsp_pkg::ST_SCAN_CHK;
        end else if (stat.out_free) begin
          cmd.op     = swsp_pkg::OP_COMMIT;
          state_next = swsp_pkg::ST_IDLE;
        end else begin
          // hold until the output register is taken
          state_next = swsp_pkg::ST_EXEC;
        end
      end
      swsp_pkg::ST_RD_WAIT,
      swsp_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.op     = swsp_pkg::OP_COMMIT;
          state_next = swsp_pkg::ST_IDLE;
        end
      end
      swsp_pkg::ST_SCAN_CHK: begin
        if (stat.pos_at_end) begin
          state_next = swsp_pkg::ST_SHIFT_CHK;
        end else begin
          cmd.op     = swsp_pkg::OP_RD_POS;
          state_next = swsp_pkg::ST_SCAN_CMP;
        end
      end
      swsp_pkg::ST_SCAN_CMP: begin
        if (stat.entry_lt) begin
          cmd.op     = swsp_pkg::OP_POS_INC;
          state_next = swsp_pkg::ST_SCAN_CHK;
        end else begin
          state_next = swsp_pkg::ST_SHIFT_CHK;
        end
      end
      swsp_pkg::ST_SHIFT_CHK: begin
        if (stat.k_gt_pos) begin
          cmd.op     = swsp_pkg::OP_RD_KM1;
          state_next = swsp_pkg::ST_SHIFT_WR;
        end else begin
          state_next = swsp_pkg::ST_FINISH;
        end
      end
      swsp_pkg::ST_SHIFT_WR: begin
        cmd.op     = swsp_pkg::OP_WR_K;
        state_next = swsp_pkg::ST_SHIFT_CHK;
      end
      default: begin
        state_next = swsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/swsp_dp.sv -----
// ----------------------------------------------------------------------------
// swsp_dp
// Datapath: request register, counters, run flags, split table memory and
// the output register.
// ----------------------------------------------------------------------------
module swsp_dp #(
  parameter int MAX_SPLITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [swsp_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [swsp_pkg::REQ_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [swsp_pkg::M_TDATA_W-1:0]     m_tdata,
  input  swsp_pkg::dp_cmd_t                  cmd,
  output swsp_pkg::dp_stat_t                 stat
);

  localparam int CNT_W  = $clog2(MAX_SPLITS + 1);
  localparam int ADDR_W = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
  localparam int CMP_W  = (CNT_W > swsp_pkg::IDX_W) ? CNT_W : swsp_pkg::IDX_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPLITS);
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SPLITS);

  // latched request
  swsp_pkg::req_t                 req;
  logic [swsp_pkg::TIME_W-1:0]    tval;
  logic [swsp_pkg::LABEL_W-1:0]   lab;
  logic [swsp_pkg::IDX_W-1:0]     idx;

  // stopwatch state
  logic [swsp_pkg::TIME_W-1:0]    net_count;
  logic                           run_flag, pause_flag, done_flag;
  logic [CNT_W-1:0]               entry_count;
  logic [CNT_W-1:0]               pos, k;

  // table
  logic [swsp_pkg::ENTRY_W-1:0]   mem [MAX_SPLITS];
  logic [swsp_pkg::ENTRY_W-1:0]   rdata;
  logic                           mem_re, mem_we;
  logic [ADDR_W-1:0]              mem_raddr, mem_waddr;
  logic [swsp_pkg::ENTRY_W-1:0]   mem_wdata;

  // commit values
  logic [swsp_pkg::TIME_W-1:0]    net_next;
  logic                           run_next, pause_next, done_next;
  logic [CNT_W-1:0]               count_next;
  logic [swsp_pkg::TIME_W-1:0]    elapsed_cur;
  logic                           full, rd_valid, dropped;
  logic [CMP_W-1:0]               idx_c;
  logic [CNT_W-1:0]               km1;
  logic [swsp_pkg::TIME_W-1:0]    rd_time;
  logic [swsp_pkg::LABEL_W-1:0]   rd_label;
  swsp_pkg::result_t              res, out_q;
  logic                           commit;

  assign commit      = (cmd.op == swsp_pkg::OP_COMMIT);
  assign full        = (entry_count >= MAX_CNT);
  assign idx_c       = CMP_W'(idx);
  assign km1         = k - CNT_W'(1);
  assign rd_valid    = (idx_c < CMP_W'(entry_count)) && (idx_c < MAX_CMP);
  assign elapsed_cur = (run_flag || done_flag) ? net_count : '0;
  assign rd_time     = rdata[swsp_pkg::ENTRY_W-1 -: swsp_pkg::TIME_W];
  assign rd_label    = rdata[swsp_pkg::LABEL_W-1:0];

  assign stat.req        = req;
  assign stat.full       = full;
  assign stat.pos_at_end = (pos == entry_count);
  assign stat.entry_lt   = (rd_time < tval);
  assign stat.k_gt_pos   = (k > pos);
  assign stat.out_free   = !m_tvalid || m_tready;

  // request effect on the run state
  always_comb begin
    net_next   = net_count;
    run_next   = run_flag;
    pause_next = pause_flag;
    done_next  = done_flag;
    count_next = entry_count;
    dropped    = 1'b0;
    unique case (req)
      swsp_pkg::REQ_TICK: begin
        if (run_flag && !pause_flag && (net_count != '1)) begin
          net_next = net_count + swsp_pkg::TIME_W'(1);
        end
      end
      swsp_pkg::REQ_START: begin
        if (!run_flag && !done_flag) begin
          net_next   = '0;
          run_next   = 1'b1;
          pause_next = 1'b0;
          count_next = '0;
        end
      end
      swsp_pkg::REQ_STOP,
      swsp_pkg::REQ_STOP_AT: begin
        if (run_flag) begin
          if (req == swsp_pkg::REQ_STOP_AT) begin
            net_next = tval;
          end
          run_next   = 1'b0;
          pause_next = 1'b0;
          done_next  = 1'b1;
        end
      end
      swsp_pkg::REQ_RESET: begin
        net_next   = '0;
        run_next   = 1'b0;
        pause_next = 1'b0;
        done_next  = 1'b0;
        count_next = '0;
      end
      swsp_pkg::REQ_PAUSE: begin
        if (run_flag && !pause_flag) begin
          pause_next = 1'b1;
        end
      end
      swsp_pkg::REQ_RESUME: begin
        if (run_flag && pause_flag) begin
          pause_next = 1'b0;
        end
      end
      swsp_pkg::REQ_SPLIT_NOW,
      swsp_pkg::REQ_SPLIT_AT: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          count_next = entry_count + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res               = '0;
    res.elapsed_ticks = (run_next || done_next) ? net_next : '0;
    res.is_running    = run_next;
    res.is_paused     = pause_next;
    res.is_finished   = done_next;
    res.split_total   = swsp_pkg::TOTAL_W'(count_next);
    res.split_dropped = dropped;
    if (req == swsp_pkg::REQ_READ_SPLIT && rd_valid) begin
      res.split_valid = 1'b1;
      res.split_time  = rd_time;
      res.split_label = rd_label;
    end
  end

  // memory ports
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (cmd.op)
      swsp_pkg::OP_RD_IDX: begin
        mem_re    = 1'b1;
        mem_raddr = idx_c[ADDR_W-1:0];
      end
      swsp_pkg::OP_RD_POS: begin
        mem_re    = 1'b1;
        mem_raddr = pos[ADDR_W-1:0];
      end
      swsp_pkg::OP_RD_KM1: begin
        mem_re    = 1'b1;
        mem_raddr = km1[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    if (cmd.op == swsp_pkg::OP_WR_K) begin
      mem_we    = 1'b1;
      mem_waddr = k[ADDR_W-1:0];
    end else if (commit && !full && req == swsp_pkg::REQ_SPLIT_NOW) begin
      mem_we    = 1'b1;
      mem_waddr = entry_count[ADDR_W-1:0];
      mem_wdata = {elapsed_cur, lab};
    end else if (commit && !full && req == swsp_pkg::REQ_SPLIT_AT) begin
      mem_we    = 1'b1;
      mem_waddr = pos[ADDR_W-1:0];
      mem_wdata = {tval, lab};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (cmd.op == swsp_pkg::OP_LOAD) begin
      req  <= swsp_pkg::req_t'(s_tuser);
      tval <= s_tdata[swsp_pkg::TIME_W-1:0];
      lab  <= s_tdata[swsp_pkg::TIME_W +: swsp_pkg::LABEL_W];
      idx  <= s_tdata[swsp_pkg::TIME_W + swsp_pkg::LABEL_W +: swsp_pkg::IDX_W];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      net_count   <= '0;
      run_flag    <= 1'b0;
      pause_flag  <= 1'b0;
      done_flag   <= 1'b0;
      entry_count <= '0;
      pos         <= '0;
      k           <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      unique case (cmd.op)
        swsp_pkg::OP_LOAD: begin
          pos <= '0;
          k   <= entry_count;
        end
        swsp_pkg::OP_POS_INC: begin
          pos <= pos + CNT_W'(1);
        end
        swsp_pkg::OP_WR_K: begin
          k <= km1;
        end
        default: begin
        end
      endcase
      if (commit) begin
        net_count   <= net_next;
        run_flag    <= run_next;
        pause_flag  <= pause_next;
        done_flag   <= done_next;
        entry_count <= count_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign m_tdata = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= MAX_CNT)
    else $error("split count above table depth");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!m_tvalid || m_tready))
    else $error("commit overwrote an untaken result");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("commit did not present a result");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == swsp_pkg::OP_POS_INC) |-> (pos < entry_count))
    else $error("scan stepped past entry count");

  a_shift_above: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == swsp_pkg::OP_WR_K) |-> (k > pos))
    else $error("shift wrote at or below insert slot");

endmodule

// ----- rtl/pausable_stopwatch_with_splits_core.sv -----
// ----------------------------------------------------------------------------
// pausable_stopwatch_with_splits_core
// Pausable tick stopwatch with a table of split times and labels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one beat is one request. s_tuser carries the request
//    code (tick, start, stop, stop at, reset, pause, resume, split now,
//    split at, read split); s_tdata carries time, label and table index.
//  - Output channel m_*: exactly one result beat per request, in order,
//    showing the state after that request.
//  - Throughput: one request at a time. Tick and control requests, split
//    now and a split at into a full table are accepted, then committed;
//    read split adds one registered table read before the commit. Split at
//    walks the table through its single read port: it scans entries until
//    one is not earlier than the split time, moves each later entry up one
//    slot, then commits. Each commit waits for a free output register.
//  - Result: the result beat is registered at the commit and is valid from
//    the cycle after it, in which the next beat can already be accepted.
//  - Stall: a waiting result does not block the next accept; the following
//    commit waits until the output register is taken.
//  - Reset (rst, synchronous): clears flags, count and split total; no beat
//    is accepted while it is held. Table contents are left as they are and
//    are only reported below the split total.
// ----------------------------------------------------------------------------
module pausable_stopwatch_with_splits_core #(
  parameter int MAX_SPLITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata, low bit up: time_value[31:0], label_id[15:0], split_index[5:0],
  // 2 zero pad bits
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [swsp_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type[3:0]
  input  logic [swsp_pkg::REQ_W-1:0]     s_tuser,
  // m_tdata, low bit up: elapsed_ticks[31:0], is_running, is_paused,
  // is_finished, split_total[6:0], split_time[31:0], split_label[15:0],
  // split_valid, split_dropped, 4 zero pad bits
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [swsp_pkg::M_TDATA_W-1:0] m_tdata
);

  // command and status between sequencer and datapath
  swsp_pkg::dp_cmd_t  cmd;
  swsp_pkg::dp_stat_t stat;

  swsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swsp_dp #(
    .MAX_SPLITS (MAX_SPLITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
